// ===== hw/rtl/rtcar_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcar_pkg
// Types and constants shared by the RTC alarm register block.
// ----------------------------------------------------------------------------
package rtcar_pkg;

	localparam int TIME_W     = 64;
	localparam int WORD_W     = 32;
	localparam int NS_TICK_W  = 30;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [NS_TICK_W-1:0] NS_PER_TICK_RESET = NS_TICK_W'(100);

	// configuration register word indexes
	localparam logic [CFG_ADDR_W-3:0] CFG_NS_PER_TICK = '0;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_TIMELO   = 3'd0,
		REG_TIMEHI   = 3'd1,
		REG_ALARMLO  = 3'd2,
		REG_ALARMHI  = 3'd3,
		REG_IRQEN    = 3'd4,
		REG_CLRALARM = 3'd5,
		REG_STATUS   = 3'd6,
		REG_CLRIRQ   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		func_t              func;
		reg_idx_t           reg_index;
		logic [WORD_W-1:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_data;
		logic               irq_line;
	} rsp_t;

endpackage

// ===== hw/rtl/rtc_alarm_register_block.sv =====
// ----------------------------------------------------------------------------
// rtc_alarm_register_block
// 64-bit nanosecond real-time clock with one alarm behind eight 32-bit
// registers; transactions are ticks, register reads and register writes.
// ----------------------------------------------------------------------------
// Each transaction on req is registered in req_s1, then processed against the
// clock state when the rsp register can take it, and its result is captured
// in the rsp register. One transaction can be taken every cycle while
// rsp_stall does not hold the output. The cycle is set by the 64-bit
// saturating time add followed by the 64-bit alarm compare. A read of TIMELO
// snapshots the whole time so a following TIMEHI read is coherent; writing
// ALARMLO arms the alarm. ns_per_tick sits at byte address 0 of the APB port
// and resets to 100.
module rtc_alarm_register_block (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtcar_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rtcar_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rtcar_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rtcar_pkg::req_t               req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rtcar_pkg::rsp_t               rsp
);
	import rtcar_pkg::*;

	logic [NS_TICK_W-1:0] ns_per_tick_q;
	logic [TIME_W-1:0]    cur_time_q, time_latch_q, alarm_q;
	logic                 armed_q, irq_en_q, irq_pend_q;

	logic [TIME_W-1:0]    cur_time_n, time_latch_n, alarm_n;
	logic                 armed_n, irq_en_n, irq_pend_n;
	logic [TIME_W:0]      tick_sum;
	logic [WORD_W-1:0]    rd_data;
	logic                 do_check;

	req_t                 req_s1;
	logic                 vld_s1;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic                 adv, accept, cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[CFG_ADDR_W-1:2] == CFG_NS_PER_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_per_tick_q <= NS_PER_TICK_RESET;
		end else if (cfg_wr) begin
			ns_per_tick_q <= pwdata[NS_TICK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[CFG_ADDR_W-1:2] == CFG_NS_PER_TICK) begin
			prdata = CFG_DATA_W'(ns_per_tick_q);
		end
	end

	// ---------------- flow control ----------------
	assign adv       = vld_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = vld_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (accept) begin
			req_s1 <= req;
		end
	end

	// ---------------- transaction processing ----------------
	// The alarm check runs after every tick and write, so the state never
	// holds an armed alarm that is already due; reads need no check.
	always_comb begin
		cur_time_n   = cur_time_q;
		time_latch_n = time_latch_q;
		alarm_n      = alarm_q;
		armed_n      = armed_q;
		irq_en_n     = irq_en_q;
		irq_pend_n   = irq_pend_q;
		rd_data      = '0;
		do_check     = 1'b0;
		tick_sum     = {1'b0, cur_time_q} + (TIME_W+1)'(ns_per_tick_q);

		unique case (req_s1.func)
			FUNC_TICK: begin
				cur_time_n = tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
				do_check   = 1'b1;
			end
			FUNC_READ: begin
				unique case (req_s1.reg_index)
					REG_TIMELO: begin
						time_latch_n = cur_time_q;
						rd_data      = cur_time_q[WORD_W-1:0];
					end
					REG_TIMEHI:  rd_data = time_latch_q[TIME_W-1:WORD_W];
					REG_ALARMLO: rd_data = alarm_q[WORD_W-1:0];
					REG_ALARMHI: rd_data = alarm_q[TIME_W-1:WORD_W];
					REG_STATUS:  rd_data = WORD_W'(armed_q);
					REG_IRQEN, REG_CLRALARM, REG_CLRIRQ: rd_data = '0;
				endcase
			end
			FUNC_WRITE: begin
				do_check = 1'b1;
				unique case (req_s1.reg_index)
					REG_TIMELO:  cur_time_n[WORD_W-1:0] = req_s1.write_data;
					REG_TIMEHI:  cur_time_n[TIME_W-1:WORD_W] = req_s1.write_data;
					REG_ALARMLO: begin
						alarm_n[WORD_W-1:0] = req_s1.write_data;
						armed_n             = 1'b1;
					end
					REG_ALARMHI:  alarm_n[TIME_W-1:WORD_W] = req_s1.write_data;
					REG_IRQEN:    irq_en_n   = req_s1.write_data[0];
					REG_CLRALARM: armed_n    = 1'b0;
					REG_CLRIRQ:   irq_pend_n = 1'b0;
					REG_STATUS:   ;
				endcase
			end
			FUNC_NOP: ;
		endcase

		if (do_check && armed_n && (cur_time_n >= alarm_n)) begin
			armed_n    = 1'b0;
			irq_pend_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_time_q   <= '0;
			time_latch_q <= '0;
			alarm_q      <= '0;
			armed_q      <= 1'b0;
			irq_en_q     <= 1'b0;
			irq_pend_q   <= 1'b0;
		end else if (adv) begin
			cur_time_q   <= cur_time_n;
			time_latch_q <= time_latch_n;
			alarm_q      <= alarm_n;
			armed_q      <= armed_n;
			irq_en_q     <= irq_en_n;
			irq_pend_q   <= irq_pend_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.read_data <= rd_data;
			rsp_q.irq_line  <= irq_pend_n && irq_en_n;
		end
	end

	// ---------------- assertions ----------------
	a_no_due_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		!(armed_q && (cur_time_q >= alarm_q)))
		else $error("armed alarm left pending past its time");

	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (rsp_q.irq_line == (irq_pend_q && irq_en_q)))
		else $error("irq_line does not follow pending and enable");

	a_tick_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.func == FUNC_TICK) |=> (cur_time_q >= $past(cur_time_q)))
		else $error("tick moved time backwards");

	a_pend_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_pend_q) |-> $past(armed_q) || $past(req_s1.reg_index) == REG_ALARMLO)
		else $error("interrupt went pending without an armed alarm");

endmodule
